>>> rtl/core/lfrc_pkg.sv
// Shared types and constants for the link frame receive classifier.
// Depends on nothing; imported by every module of the block.
`default_nettype none

package lfrc_pkg;

	localparam int unsigned FRAME_BYTES = 1600;
	localparam int unsigned HDR_BYTES   = 12;
	localparam int unsigned MAX_PAYLOAD = FRAME_BYTES - HDR_BYTES;
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [15:0] POS_TYPE    = 16'd0;
	localparam logic [15:0] POS_LEN     = 16'd2;
	localparam logic [15:0] POS_OFF     = 16'd4;
	localparam logic [15:0] POS_CSUM    = 16'd6;
	localparam logic [15:0] POS_MAX     = 16'hFFFF;
	localparam logic [3:0]  NIBBLE_MASK = 4'hF;

	typedef enum logic [1:0] {
		CLASS_IDLE      = 2'd0,
		CLASS_MALFORMED = 2'd1,
		CLASS_BAD_CSUM  = 2'd2,
		CLASS_DATA      = 2'd3
	} frame_class_t;

	typedef struct packed {
		logic [7:0]  hdr0;
		logic [15:0] len;
		logic [15:0] off;
		logic [15:0] csum;
		logic [15:0] sum;
		logic        short_frame;
	} frame_rec_t;

endpackage

`default_nettype wire

>>> rtl/core/lfrc_front.sv
// Front end: takes bytes, captures header fields and keeps the byte sum.
// Emits one frame record per transaction end. Uses lfrc_pkg.
`default_nettype none

module lfrc_front (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                beat,
	input  wire logic [7:0]          rx_byte,
	input  wire logic                end_of_transaction,
	output logic                     push,
	output lfrc_pkg::frame_rec_t     rec
);
	import lfrc_pkg::*;

	logic [15:0] pos_q;
	logic [15:0] sum_q;
	logic [7:0]  hdr0_q;
	logic [15:0] len_q;
	logic [15:0] off_q;
	logic [15:0] csum_q;

	logic [7:0]  hdr0_n;
	logic [15:0] len_n;
	logic [15:0] off_n;
	logic [15:0] csum_n;
	logic [15:0] sum_n;
	logic [16:0] span;
	logic [16:0] count;
	logic        in_span;
	logic        csum_byte;

	always_comb begin
		hdr0_n = hdr0_q;
		len_n  = len_q;
		off_n  = off_q;
		csum_n = csum_q;
		unique case (pos_q)
			POS_TYPE:          hdr0_n       = rx_byte;
			POS_LEN:           len_n[7:0]   = rx_byte;
			POS_LEN + 16'd1:   len_n[15:8]  = rx_byte;
			POS_OFF:           off_n[7:0]   = rx_byte;
			POS_OFF + 16'd1:   off_n[15:8]  = rx_byte;
			POS_CSUM:          csum_n[7:0]  = rx_byte;
			POS_CSUM + 16'd1:  csum_n[15:8] = rx_byte;
			default: ;
		endcase
		span      = {1'b0, len_n} + 17'(HDR_BYTES);
		in_span   = {1'b0, pos_q} < span;
		csum_byte = (pos_q == POS_CSUM) || (pos_q == POS_CSUM + 16'd1);
		sum_n     = sum_q + ((in_span && !csum_byte) ? {8'd0, rx_byte} : 16'd0);
		count     = {1'b0, pos_q} + 17'd1;
	end

	assign push            = beat && end_of_transaction;
	assign rec.hdr0        = hdr0_n;
	assign rec.len         = len_n;
	assign rec.off         = off_n;
	assign rec.csum        = csum_n;
	assign rec.sum         = sum_n;
	assign rec.short_frame = count < span;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			sum_q  <= '0;
			hdr0_q <= '0;
			len_q  <= '0;
			off_q  <= '0;
			csum_q <= '0;
		end else if (beat) begin
			if (end_of_transaction) begin
				pos_q  <= '0;
				sum_q  <= '0;
				hdr0_q <= '0;
				len_q  <= '0;
				off_q  <= '0;
				csum_q <= '0;
			end else begin
				if (pos_q != POS_MAX) pos_q <= pos_q + 16'd1;
				sum_q  <= sum_n;
				hdr0_q <= hdr0_n;
				len_q  <= len_n;
				off_q  <= off_n;
				csum_q <= csum_n;
			end
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/lfrc_queue.sv
// Short record queue between front end and back end.
// Holds frame records of type lfrc_pkg::frame_rec_t.
`default_nettype none

module lfrc_queue (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	input  wire lfrc_pkg::frame_rec_t push_rec,
	input  wire logic                pop,
	output lfrc_pkg::frame_rec_t     head_rec,
	output logic                     full,
	output logic                     empty
);
	import lfrc_pkg::*;

	frame_rec_t          mem [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   cnt_q;

	assign full     = cnt_q == QCNT_W'(QUEUE_DEPTH);
	assign empty    = cnt_q == '0;
	assign head_rec = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) mem[wr_ptr_q] <= push_rec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)      cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/lfrc_back.sv
// Back end: classifies queued frame records and holds the result register.
// Uses lfrc_pkg.
`default_nettype none

module lfrc_back (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire lfrc_pkg::frame_rec_t head_rec,
	input  wire logic                 empty,
	output logic                      pop,
	output logic                      result_valid,
	input  wire logic                 result_ready,
	output logic [1:0]                frame_class,
	output logic [3:0]                iface_type,
	output logic [3:0]                iface_num,
	output logic [15:0]               payload_len,
	output logic [15:0]               payload_offset
);
	import lfrc_pkg::*;

	logic         valid_q;
	frame_class_t cls;
	frame_class_t cls_q;
	logic [7:0]   hdr0_q;
	logic [15:0]  len_q;
	logic [15:0]  off_q;

	always_comb begin
		priority if (head_rec.len == '0)
			cls = CLASS_IDLE;
		else if (head_rec.off != 16'(HDR_BYTES) || head_rec.len > 16'(MAX_PAYLOAD)
		         || head_rec.short_frame)
			cls = CLASS_MALFORMED;
		else if (head_rec.sum != head_rec.csum)
			cls = CLASS_BAD_CSUM;
		else
			cls = CLASS_DATA;
	end

	assign pop = !empty && (!valid_q || result_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (result_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cls_q  <= cls;
			hdr0_q <= head_rec.hdr0;
			len_q  <= head_rec.len;
			off_q  <= head_rec.off;
		end
	end

	assign result_valid   = valid_q;
	assign frame_class    = cls_q;
	assign iface_type     = hdr0_q[3:0] & NIBBLE_MASK;
	assign iface_num      = hdr0_q[7:4] & NIBBLE_MASK;
	assign payload_len    = len_q;
	assign payload_offset = off_q;

endmodule

`default_nettype wire

>>> rtl/core/link_frame_rx_classifier_core.sv
// Top level of the link frame receive classifier.
// Instantiates lfrc_front, lfrc_queue and lfrc_back; uses lfrc_pkg.
//
//   channel   direction  handshake                    payload
//   byte      in         byte_valid / byte_ready      rx_byte, end_of_transaction
//   result    out        result_valid / result_ready  frame_class, iface_type,
//                                                     iface_num, payload_len,
//                                                     payload_offset
//
// One byte per cycle while byte_ready is high; each beat updates header and 16-bit sum.
// The closing beat queues its record; result_valid rises once the back end pops it.
// A four-record queue sits between front and back; byte_ready drops only when it is full.
// Reset clears the running sum, captured header fields, queue and result valid.
`default_nettype none

module link_frame_rx_classifier_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        byte_valid,
	output logic             byte_ready,
	input  wire logic [7:0]  rx_byte,
	input  wire logic        end_of_transaction,
	output logic             result_valid,
	input  wire logic        result_ready,
	output logic [1:0]       frame_class,
	output logic [3:0]       iface_type,
	output logic [3:0]       iface_num,
	output logic [15:0]      payload_len,
	output logic [15:0]      payload_offset
);
	import lfrc_pkg::*;

	logic       beat;
	logic       push;
	logic       pop;
	logic       q_full;
	logic       q_empty;
	frame_rec_t push_rec;
	frame_rec_t head_rec;

	assign byte_ready = !q_full;
	assign beat       = byte_valid && byte_ready;

	lfrc_front u_front (
		.clk                (clk),
		.arst_n             (arst_n),
		.beat               (beat),
		.rx_byte            (rx_byte),
		.end_of_transaction (end_of_transaction),
		.push               (push),
		.rec                (push_rec)
	);

	lfrc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_rec (push_rec),
		.pop      (pop),
		.head_rec (head_rec),
		.full     (q_full),
		.empty    (q_empty)
	);

	lfrc_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.head_rec       (head_rec),
		.empty          (q_empty),
		.pop            (pop),
		.result_valid   (result_valid),
		.result_ready   (result_ready),
		.frame_class    (frame_class),
		.iface_type     (iface_type),
		.iface_num      (iface_num),
		.payload_len    (payload_len),
		.payload_offset (payload_offset)
	);

	a_drain_empty: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_ready && q_empty |=> !result_valid)
		else $error("result valid after draining with empty queue");

	a_idle_len: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && frame_class == CLASS_IDLE |-> payload_len == 16'd0)
		else $error("idle class with nonzero length");

	a_data_hdr: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && frame_class == CLASS_DATA |->
			payload_offset == 16'(HDR_BYTES) && payload_len != 16'd0
			&& payload_len <= 16'(MAX_PAYLOAD))
		else $error("data class with bad header fields");

	a_pop_load: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> result_valid)
		else $error("queue pop did not load result register");

endmodule

`default_nettype wire
